// ===== hdl/tllc_pkg.sv =====
`timescale 1ns / 1ps
// Package for the two-level LRU tag cache: widths, parameter defaults and
// the sequencer state type. No dependencies.
package tllc_pkg;

  localparam int KEY_W   = 32;
  localparam int TAG_W   = 32;
  localparam int STAMP_W = 64;
  localparam int ENTRY_W = TAG_W + STAMP_W;

  localparam int DEF_NEAR_WAYS = 4;
  localparam int DEF_NEAR_SETS = 128;
  localparam int DEF_FAR_WAYS  = 8;
  localparam int DEF_FAR_SETS  = 2048;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_NEAR_RD,
    ST_NEAR_UPD,
    ST_FAR_RD,
    ST_FAR_UPD
  } tllc_state_t;

endpackage

// ===== hdl/two_level_lru_cache_lookup_top.sv =====
`timescale 1ns / 1ps
// Top level of the two-level LRU tag cache: set memories, lookup logic,
// set-index remainder unit and sequencer. Depends on tllc_pkg.
//
// Each accepted transaction carries one line key and yields exactly one
// result transaction. After reset a clearing pass writes every set row of
// both levels to empty, one row per cycle, until every row of the larger
// level is written; no key is taken meanwhile. Each level keeps one row
// per set in a synchronous memory with a registered read port and its own
// write port, and every access is a read of the set row followed by a
// write back. With power-of-two set counts an L1 hit is a near read and a
// near update, an L1 miss adds a far read and far update, and an L1 miss
// that evicts does the far pair twice (victim insert into L2, then the L2
// lookup). With a set count that is not a power of two, the set index
// comes from a remainder unit that takes four key bits per cycle by
// compare and subtract, run once per key and again for an evicted key. A
// result may wait in the output register while the next key is accepted;
// the sequencer holds before its final write until that register is free.
module two_level_lru_cache_lookup_top
  import tllc_pkg::*;
#(
  parameter int NEAR_WAYS = DEF_NEAR_WAYS,
  parameter int NEAR_SETS = DEF_NEAR_SETS,
  parameter int FAR_WAYS  = DEF_FAR_WAYS,
  parameter int FAR_SETS  = DEF_FAR_SETS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [KEY_W-1:0] line_key,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             first_level_hit,
  output logic             second_level_asked,
  output logic             second_level_hit
);

  localparam int NSW = (NEAR_SETS > 1) ? $clog2(NEAR_SETS) : 1;
  localparam int FSW = (FAR_SETS > 1) ? $clog2(FAR_SETS) : 1;
  localparam int NWW = (NEAR_WAYS > 1) ? $clog2(NEAR_WAYS) : 1;
  localparam int FWW = (FAR_WAYS > 1) ? $clog2(FAR_WAYS) : 1;
  localparam int CLR_N = (NEAR_SETS > FAR_SETS) ? NEAR_SETS : FAR_SETS;
  localparam int CW = (CLR_N > 1) ? $clog2(CLR_N) : 1;
  localparam bit NEAR_POW2 = (NEAR_SETS & (NEAR_SETS - 1)) == 0;
  localparam bit FAR_POW2  = (FAR_SETS & (FAR_SETS - 1)) == 0;
  localparam bit SKIP_DIV  = NEAR_POW2 && FAR_POW2;
  localparam int DIG = 4;
  localparam int DSTEPS = KEY_W / DIG;
  localparam int DW = $clog2(DSTEPS);

  typedef logic [NEAR_WAYS-1:0][ENTRY_W-1:0] near_row_t;
  typedef logic [FAR_WAYS-1:0][ENTRY_W-1:0]  far_row_t;

  // Set memories: one row per set, each way {tag, stamp}
  near_row_t nmem [NEAR_SETS];
  far_row_t  fmem [FAR_SETS];
  near_row_t n_rdata, n_wrow, n_wdata;
  far_row_t  f_rdata, f_wrow, f_wdata;
  logic [NSW-1:0] n_waddr;
  logic [FSW-1:0] f_waddr;
  logic n_we, f_we;

  tllc_state_t state, state_next;

  logic [CW-1:0]      clr_cnt;
  logic [DW-1:0]      dcnt;
  logic [KEY_W-1:0]   dkey;
  logic [NSW-1:0]     rn;
  logic [FSW-1:0]     rf;
  logic [KEY_W-1:0]   key;
  logic [KEY_W-1:0]   fkey;
  logic [NSW-1:0]     near_set;
  logic [FSW-1:0]     far_set;
  logic [FSW-1:0]     key_fset;
  logic               vict;
  logic [STAMP_W-1:0] near_tick;
  logic [STAMP_W-1:0] far_tick;

  logic clearing, accept, emit, out_free, div_last, near_clr, far_clr;

  // Remainder unit: four key bits per cycle into both set remainders
  logic [NSW+DIG-1:0] rn_sh;
  logic [FSW+DIG-1:0] rf_sh;
  logic [NSW-1:0] rn_next;
  logic [FSW-1:0] rf_next;

  always_comb begin
    rn_sh = {rn, dkey[KEY_W-1 -: DIG]};
    rf_sh = {rf, dkey[KEY_W-1 -: DIG]};
    for (int i = DIG - 1; i >= 0; i--) begin
      if (rn_sh >= (NSW+DIG)'(NEAR_SETS << i))
        rn_sh = rn_sh - (NSW+DIG)'(NEAR_SETS << i);
      if (rf_sh >= (FSW+DIG)'(FAR_SETS << i))
        rf_sh = rf_sh - (FSW+DIG)'(FAR_SETS << i);
    end
    rn_next = NSW'(rn_sh);
    rf_next = FSW'(rf_sh);
  end

  // Near lookup on the row read for near_set
  logic n_hit, n_empty, n_evict;
  logic [NWW-1:0] n_hit_way, n_empty_way, n_vic_way, n_slot;
  logic [STAMP_W-1:0] n_vic_stamp;
  logic [TAG_W-1:0] n_vic_tag;

  always_comb begin
    n_hit = 1'b0;
    n_empty = 1'b0;
    n_hit_way = '0;
    n_empty_way = '0;
    n_vic_way = '0;
    n_vic_stamp = n_rdata[0][STAMP_W-1:0];
    for (int w = 0; w < NEAR_WAYS; w++) begin
      if (!n_hit && n_rdata[w][ENTRY_W-1:STAMP_W] == key) begin
        n_hit = 1'b1;
        n_hit_way = NWW'(w);
      end
      if (n_rdata[w][ENTRY_W-1:STAMP_W] == '0) begin
        n_empty = 1'b1;
        n_empty_way = NWW'(w);
      end
    end
    for (int w = 1; w < NEAR_WAYS; w++) begin
      if (n_rdata[w][STAMP_W-1:0] < n_vic_stamp) begin
        n_vic_stamp = n_rdata[w][STAMP_W-1:0];
        n_vic_way = NWW'(w);
      end
    end
    n_evict = !n_hit && !n_empty;
    n_slot = n_hit ? n_hit_way : (n_empty ? n_empty_way : n_vic_way);
    n_vic_tag = n_rdata[n_vic_way][ENTRY_W-1:STAMP_W];
    n_wrow = n_rdata;
    n_wrow[n_slot] = {key, near_tick + STAMP_W'(1)};
  end

  // Far lookup on the row read for far_set
  logic f_hit, f_empty;
  logic [FWW-1:0] f_hit_way, f_empty_way, f_vic_way, f_slot;
  logic [STAMP_W-1:0] f_vic_stamp;

  always_comb begin
    f_hit = 1'b0;
    f_empty = 1'b0;
    f_hit_way = '0;
    f_empty_way = '0;
    f_vic_way = '0;
    f_vic_stamp = f_rdata[0][STAMP_W-1:0];
    for (int w = 0; w < FAR_WAYS; w++) begin
      if (!f_hit && f_rdata[w][ENTRY_W-1:STAMP_W] == fkey) begin
        f_hit = 1'b1;
        f_hit_way = FWW'(w);
      end
      if (f_rdata[w][ENTRY_W-1:STAMP_W] == '0) begin
        f_empty = 1'b1;
        f_empty_way = FWW'(w);
      end
    end
    for (int w = 1; w < FAR_WAYS; w++) begin
      if (f_rdata[w][STAMP_W-1:0] < f_vic_stamp) begin
        f_vic_stamp = f_rdata[w][STAMP_W-1:0];
        f_vic_way = FWW'(w);
      end
    end
    f_slot = f_hit ? f_hit_way : (f_empty ? f_empty_way : f_vic_way);
    f_wrow = f_rdata;
    f_wrow[f_slot] = {fkey, far_tick + STAMP_W'(1)};
  end

  assign out_free = !out_valid || !out_stall;
  assign div_last = (dcnt == DW'(DSTEPS - 1));

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:    if (clr_cnt == CW'(CLR_N - 1)) state_next = ST_IDLE;
      ST_IDLE:     if (in_valid) state_next = SKIP_DIV ? ST_NEAR_RD : ST_DIV;
      ST_DIV:      if (div_last) state_next = vict ? ST_FAR_RD : ST_NEAR_RD;
      ST_NEAR_RD:  state_next = ST_NEAR_UPD;
      ST_NEAR_UPD: begin
        if (n_hit) begin
          if (out_free) state_next = ST_IDLE;
        end else if (n_evict && !SKIP_DIV) begin
          state_next = ST_DIV;
        end else begin
          state_next = ST_FAR_RD;
        end
      end
      ST_FAR_RD:   state_next = ST_FAR_UPD;
      ST_FAR_UPD: begin
        if (vict) state_next = ST_FAR_RD;
        else if (out_free) state_next = ST_IDLE;
      end
      default:     state_next = ST_CLEAR;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    clearing = (state == ST_CLEAR);
    in_stall = (state != ST_IDLE);
    accept = in_valid && !in_stall;
    near_clr = clearing && ({1'b0, clr_cnt} < (CW+1)'(NEAR_SETS));
    far_clr = clearing && ({1'b0, clr_cnt} < (CW+1)'(FAR_SETS));
    n_we = near_clr || (state == ST_NEAR_UPD && (!n_hit || out_free));
    f_we = far_clr || (state == ST_FAR_UPD && (vict || out_free));
    emit = (state == ST_NEAR_UPD && n_hit && out_free) ||
           (state == ST_FAR_UPD && !vict && out_free);
    n_waddr = clearing ? NSW'(clr_cnt) : near_set;
    f_waddr = clearing ? FSW'(clr_cnt) : far_set;
    n_wdata = clearing ? '0 : n_wrow;
    f_wdata = clearing ? '0 : f_wrow;
  end

  // Memories: registered read of the current set, write back on update, rows zeroed while clearing
  always_ff @(posedge clk) begin
    if (n_we) nmem[n_waddr] <= n_wdata;
    n_rdata <= nmem[near_set];
  end

  always_ff @(posedge clk) begin
    if (f_we) fmem[f_waddr] <= f_wdata;
    f_rdata <= fmem[far_set];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_cnt <= '0;
      near_tick <= '0;
      far_tick <= '0;
      out_valid <= 1'b0;
      vict <= 1'b0;
      dcnt <= '0;
    end else begin
      state <= state_next;
      if (clearing) clr_cnt <= clr_cnt + CW'(1);
      if (n_we && !clearing) near_tick <= near_tick + STAMP_W'(1);
      if (f_we && !clearing) far_tick <= far_tick + STAMP_W'(1);
      if (emit) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      if (state == ST_DIV) dcnt <= dcnt + DW'(1);
      if (accept) begin
        vict <= 1'b0;
        dcnt <= '0;
      end
      if (state == ST_NEAR_UPD && n_evict) begin
        vict <= 1'b1;
        dcnt <= '0;
      end
      if (state == ST_FAR_UPD && vict) vict <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      key <= line_key;
      dkey <= line_key;
      rn <= '0;
      rf <= '0;
      near_set <= NSW'(line_key) & NSW'(NEAR_SETS - 1);
      key_fset <= FSW'(line_key) & FSW'(FAR_SETS - 1);
    end
    if (state == ST_DIV) begin
      dkey <= {dkey[KEY_W-DIG-1:0], DIG'(0)};
      rn <= rn_next;
      rf <= rf_next;
      if (div_last) begin
        if (vict) begin
          far_set <= rf_next;
        end else begin
          near_set <= rn_next;
          key_fset <= rf_next;
        end
      end
    end
    if (state == ST_NEAR_UPD && !n_hit) begin
      if (n_evict) begin
        // evicted key goes into L2 first
        fkey <= n_vic_tag;
        dkey <= n_vic_tag;
        rn <= '0;
        rf <= '0;
        far_set <= FSW'(n_vic_tag) & FSW'(FAR_SETS - 1);
      end else begin
        fkey <= key;
        far_set <= key_fset;
      end
    end
    if (state == ST_FAR_UPD && vict) begin
      fkey <= key;
      far_set <= key_fset;
    end
    if (emit) begin
      first_level_hit <= (state == ST_NEAR_UPD);
      second_level_asked <= (state == ST_FAR_UPD);
      second_level_hit <= (state == ST_FAR_UPD) && f_hit;
    end
  end

  // Checks
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    emit |-> !(out_valid && out_stall))
    else $error("result written over one not yet taken");

  a_result_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (first_level_hit != second_level_asked) &&
                  !(second_level_hit && !second_level_asked))
    else $error("inconsistent result flags");

  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> in_stall)
    else $error("key accepted during clearing pass");

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> !emit)
    else $error("result emitted in the cycle after acceptance");

endmodule

// ===== verif/tb_two_level_lru_cache_lookup_top.sv =====
`timescale 1ns / 1ps
// Testbench for the two-level LRU tag cache top level, with its own cache
// predictor and a scoreboard of expected lookup outcomes. Depends on tllc_pkg and the top level.
module tb_two_level_lru_cache_lookup_top;
  import tllc_pkg::*;

  localparam int NW = DEF_NEAR_WAYS;
  localparam int NS = DEF_NEAR_SETS;
  localparam int FW = DEF_FAR_WAYS;
  localparam int FS = DEF_FAR_SETS;

  typedef struct packed {
    logic l1_hit;
    logic l2_asked;
    logic l2_hit;
  } lookup_outcome_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [KEY_W-1:0] line_key = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             first_level_hit;
  logic             second_level_asked;
  logic             second_level_hit;

  two_level_lru_cache_lookup_top dut (
    .clk, .rst, .in_valid, .in_stall, .line_key,
    .out_valid, .out_stall, .first_level_hit, .second_level_asked,
    .second_level_hit
  );

  // 20 ns period: high then low.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor state: tag and stamp arrays for both levels, plus their ticks.
  logic [TAG_W-1:0]   near_tag_mem [NW*NS];
  logic [STAMP_W-1:0] near_age_mem [NW*NS];
  logic [TAG_W-1:0]   far_tag_mem  [FW*FS];
  logic [STAMP_W-1:0] far_age_mem  [FW*FS];
  logic [STAMP_W-1:0] near_clock, far_clock;

  lookup_outcome_t pending_outcomes [$];
  int  mismatches = 0;
  int  keys_sent = 0;
  int  outcomes_seen = 0;
  int  near_hits = 0, far_hits = 0;
  bit  out_idle_enable = 1'b1;
  bit  in_idle_enable = 1'b1;

  // Touch one level: hit refreshes, else fill highest empty or replace oldest.
  function automatic bit touch_near(input logic [31:0] key, output bit evicted,
                                    output logic [31:0] victim_key);
    int base, empty_way, oldest;
    bit have_empty;
    base = (key % NS) * NW;
    have_empty = 0; empty_way = 0; evicted = 0; victim_key = '0;
    for (int w = 0; w < NW; w++) begin
      if (near_tag_mem[base+w] == key) begin
        near_age_mem[base+w] = near_clock;
        return 1;
      end
      if (near_tag_mem[base+w] == '0) begin
        have_empty = 1; empty_way = w;
      end
    end
    if (have_empty) begin
      near_tag_mem[base+empty_way] = key;
      near_age_mem[base+empty_way] = near_clock;
      return 0;
    end
    oldest = 0;
    for (int w = 1; w < NW; w++)
      if (near_age_mem[base+oldest] > near_age_mem[base+w]) oldest = w;
    evicted = 1;
    victim_key = near_tag_mem[base+oldest];
    near_tag_mem[base+oldest] = key;
    near_age_mem[base+oldest] = near_clock;
    return 0;
  endfunction

  function automatic bit touch_far(input logic [31:0] key);
    int base, empty_way, oldest;
    bit have_empty;
    far_clock = far_clock + 1;
    base = (key % FS) * FW;
    have_empty = 0; empty_way = 0;
    for (int w = 0; w < FW; w++) begin
      if (far_tag_mem[base+w] == key) begin
        far_age_mem[base+w] = far_clock;
        return 1;
      end
      if (far_tag_mem[base+w] == '0) begin
        have_empty = 1; empty_way = w;
      end
    end
    if (have_empty) begin
      far_tag_mem[base+empty_way] = key;
      far_age_mem[base+empty_way] = far_clock;
      return 0;
    end
    oldest = 0;
    for (int w = 1; w < FW; w++)
      if (far_age_mem[base+oldest] > far_age_mem[base+w]) oldest = w;
    far_tag_mem[base+oldest] = key;
    far_age_mem[base+oldest] = far_clock;
    return 0;
  endfunction

  function automatic lookup_outcome_t predict_lookup(input logic [31:0] key);
    lookup_outcome_t o;
    bit ev, h2;
    logic [31:0] vk;
    near_clock = near_clock + 1;
    o.l1_hit = touch_near(key, ev, vk);
    h2 = 0;
    if (!o.l1_hit) begin
      // The evicted L1 line is pushed down before the missed key is looked up.
      if (ev) void'(touch_far(vk));
      h2 = touch_far(key);
    end
    o.l2_asked = !o.l1_hit;
    o.l2_hit = h2;
    return o;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("MISMATCH at %0t: %s", $time, what);
  endtask

  // Send one key: drop valid and idle a random number of cycles, then hold
  // until accepted. With no idle cycles valid stays high into the next key.
  task automatic send_key(input logic [31:0] key);
    int gap;
    gap = in_idle_enable ? $urandom_range(0, 8) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    line_key <= key;
    pending_outcomes.push_back(predict_lookup(key));
    keys_sent++;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Output side: stall at random, check each accepted result transaction.
  initial begin
    int hold;
    lookup_outcome_t want;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      hold = out_idle_enable ? $urandom_range(0, 8) : 0;
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      outcomes_seen++;
      if (pending_outcomes.size() == 0) begin
        report_mismatch("result transaction with nothing expected");
      end else begin
        want = pending_outcomes.pop_front();
        if (first_level_hit !== want.l1_hit)
          report_mismatch($sformatf("first_level_hit %b want %b",
                                    first_level_hit, want.l1_hit));
        if (second_level_asked !== want.l2_asked)
          report_mismatch($sformatf("second_level_asked %b want %b",
                                    second_level_asked, want.l2_asked));
        if (second_level_hit !== want.l2_hit)
          report_mismatch($sformatf("second_level_hit %b want %b",
                                    second_level_hit, want.l2_hit));
        if (want.l1_hit) near_hits++;
        if (want.l2_hit) far_hits++;
      end
    end
  end

  // Extremes of the key, repeated hits, and the zero key (matches an empty way).
  task automatic test_directed_edges();
    send_key(32'h0000_0001);
    send_key(32'hFFFF_FFFF);
    send_key(32'h0000_0001);
    send_key(32'hFFFF_FFFF);
    send_key(32'h8000_0000);
    send_key(32'h0000_0000);
    send_key(32'h5555_5555);
    send_key(32'hAAAA_AAAA);
  endtask

  // Overfill one L1 set so evictions go to L2, then revisit evicted keys.
  task automatic test_eviction_chain();
    for (int i = 1; i <= 6; i++) send_key(32'd5 + i * NS);
    send_key(32'd5 + 1 * NS);
    send_key(32'd5 + 2 * NS);
    // Zero key again: set 0, not the full set, so it hits an empty way there.
    send_key(32'h0000_0000);
    send_key(32'd5 + 7 * NS);
  endtask

  // Random keys, mostly from a small pool sharing few sets so that hits, L1
  // evictions and L2 replacement all happen; the rest are random keys, zero or near all ones.
  task automatic test_random_traffic(input int count);
    logic [31:0] key;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0, 1:    key = $urandom;
        2:       key = $urandom_range(0, 3) == 0 ? 32'd0 : ~($urandom_range(0, 15));
        default: key = ($urandom_range(0, 40) * FS) + $urandom_range(0, 3);
      endcase
      send_key(key);
      if (i == count / 3) begin
        in_idle_enable = 1'b0; out_idle_enable = 1'b0;
      end
      if (i == count / 2) begin
        in_idle_enable = 1'b1; out_idle_enable = 1'b1;
      end
    end
  endtask

  initial begin
    int drain;
    for (int i = 0; i < NW*NS; i++) begin
      near_tag_mem[i] = '0; near_age_mem[i] = '0;
    end
    for (int i = 0; i < FW*FS; i++) begin
      far_tag_mem[i] = '0; far_age_mem[i] = '0;
    end
    near_clock = '0; far_clock = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_directed_edges();
    test_eviction_chain();
    test_random_traffic(1030);
    in_valid <= 1'b0;
    drain = 0;
    while (pending_outcomes.size() != 0 && drain < 100000) begin
      @(posedge clk);
      drain++;
    end
    repeat (20) @(posedge clk);
    $display("Covered %0d keys, %0d results: %0d L1 hits, %0d L2 hits.",
             keys_sent, outcomes_seen, near_hits, far_hits);
    $display("Directed extremes, zero key and eviction chain, then random mix.");
    if (mismatches == 0 && pending_outcomes.size() == 0) begin
      $display("tb_two_level_lru_cache_lookup_top: clean");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches,
               pending_outcomes.size());
      $display("tb_two_level_lru_cache_lookup_top: errors");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run including the clearing pass.
  initial begin
    #20ms;
    $display("tb_two_level_lru_cache_lookup_top: errors");
    $finish;
  end

endmodule
